// File: hw/rtl/prqs_pkg.sv
// Shared types and constants for the priority ready queue scheduler.
package prqs_pkg;

  localparam int NUM_LEVELS_DEF = 32;
  localparam int MAX_TASKS_DEF  = 32;

  localparam int CMD_W   = 2;
  localparam int TASK_W  = 5;
  localparam int PRIO_W  = 5;
  localparam int MASK_W  = 32;
  localparam int SIZE_W  = 6;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_ROTATE = 2'd2,
    CMD_QUERY  = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [TASK_W-1:0] task_id;
    logic [PRIO_W-1:0] priority_req;
  } in_t;

  typedef struct packed {
    logic              ok;
    logic              top_valid;
    logic [TASK_W-1:0] top_task;
    logic [MASK_W-1:0] ready_mask;
    logic [SIZE_W-1:0] level_size;
  } out_t;

endpackage

// File: hw/rtl/priority_ready_queue_scheduler.sv
// Top level: bitmap priority ready queue with per-level linked-list FIFOs.

// Each command is captured in an input register, and once the result register can
// accept it, one pass of logic updates the link registers, list ends, counts and ready
// bitmap and loads the result register, including the head task of the highest-priority
// non-empty level as it stands after the command. A command's result is presented on
// the result channel from the result register. A new command can be taken every cycle
// while the result channel is not stalled, because the whole update fits between the
// input register and the result register. Back-pressure on the result channel stalls
// the input register, and in_ready then drops.
module priority_ready_queue_scheduler #(
  parameter int NUM_LEVELS = prqs_pkg::NUM_LEVELS_DEF,
  parameter int MAX_TASKS  = prqs_pkg::MAX_TASKS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  prqs_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output prqs_pkg::out_t out_data
);

  // Task ids are five bits wide, so at most 32 tasks are ever stored.
  localparam int TASK_DEPTH = (MAX_TASKS < 32) ? MAX_TASKS : 32;
  localparam int TW         = $clog2(TASK_DEPTH);
  localparam int LW         = $clog2(NUM_LEVELS);
  localparam int CW         = $clog2(TASK_DEPTH + 1);

  prqs_pkg::in_t  item_r;
  logic           item_vld_r, item_vld_nxt;
  prqs_pkg::out_t res_r, res_nxt;
  logic           res_vld_r, res_vld_nxt;
  logic           adv;

  logic [TW-1:0]         next_r  [TASK_DEPTH];
  logic [TW-1:0]         prev_r  [TASK_DEPTH];
  logic [LW-1:0]         qlvl_r  [TASK_DEPTH];
  logic [TASK_DEPTH-1:0] queued_r;
  logic [TW-1:0]         head_r  [NUM_LEVELS];
  logic [TW-1:0]         tail_r  [NUM_LEVELS];
  logic [CW-1:0]         cnt_r   [NUM_LEVELS];
  logic [NUM_LEVELS-1:0] ready_r, ready_nxt;

  logic          lvl_ok, task_ok, ok;
  logic [TW-1:0] ti;
  logic [LW-1:0] pi;
  logic [CW-1:0] cnt_p, cnt_p_nxt;
  logic [TW-1:0] head_p, tail_p, nx_t, pv_t, nx_head;

  logic          next_we, prev_we, head_we, tail_we, q_set, q_clr;
  logic [TW-1:0] next_wa, next_wd, prev_wa, prev_wd, head_wd, tail_wd;

  logic          top_v;
  logic [LW-1:0] top_lvl;
  logic [TW-1:0] top_head;

  logic [NUM_LEVELS-1:0] cnt_nz;

  // Handshake and pipeline advance.
  assign adv          = item_vld_r && (!res_vld_r || out_ready);
  assign in_ready     = !item_vld_r || adv;
  assign item_vld_nxt = (in_valid && in_ready) || (item_vld_r && !adv);
  assign res_vld_nxt  = adv || (res_vld_r && !out_ready);
  assign out_valid    = res_vld_r;
  assign out_data     = res_r;

  // Field decode and state reads.
  assign lvl_ok  = {1'b0, item_r.priority_req} < (prqs_pkg::PRIO_W + 1)'(NUM_LEVELS);
  assign task_ok = {4'b0, item_r.task_id} < 9'(MAX_TASKS);
  assign ti      = item_r.task_id[TW-1:0];
  assign pi      = item_r.priority_req[LW-1:0];
  assign cnt_p   = cnt_r[pi];
  assign head_p  = head_r[pi];
  assign tail_p  = tail_r[pi];
  assign nx_t    = next_r[ti];
  assign pv_t    = prev_r[ti];
  assign nx_head = next_r[head_p];

  // Command update: at most one write to each link array and each list end.
  always_comb begin
    ok        = 1'b0;
    cnt_p_nxt = cnt_p;
    next_we   = 1'b0;
    next_wa   = '0;
    next_wd   = '0;
    prev_we   = 1'b0;
    prev_wa   = '0;
    prev_wd   = '0;
    head_we   = 1'b0;
    head_wd   = '0;
    tail_we   = 1'b0;
    tail_wd   = '0;
    q_set     = 1'b0;
    q_clr     = 1'b0;
    case (item_r.cmd)
      prqs_pkg::CMD_INSERT: begin
        if (lvl_ok && task_ok && !queued_r[ti]) begin
          ok = 1'b1;
          if (cnt_p == '0) begin
            head_we = 1'b1;
            head_wd = ti;
          end else begin
            next_we = 1'b1;
            next_wa = tail_p;
            next_wd = ti;
            prev_we = 1'b1;
            prev_wa = ti;
            prev_wd = tail_p;
          end
          tail_we   = 1'b1;
          tail_wd   = ti;
          cnt_p_nxt = cnt_p + 1'b1;
          q_set     = 1'b1;
        end
      end
      prqs_pkg::CMD_REMOVE: begin
        if (lvl_ok && task_ok && queued_r[ti] && qlvl_r[ti] == pi) begin
          ok = 1'b1;
          if (head_p == ti) begin
            head_we = 1'b1;
            head_wd = nx_t;
          end else begin
            next_we = 1'b1;
            next_wa = pv_t;
            next_wd = nx_t;
          end
          if (tail_p == ti) begin
            tail_we = 1'b1;
            tail_wd = pv_t;
          end else begin
            prev_we = 1'b1;
            prev_wa = nx_t;
            prev_wd = pv_t;
          end
          cnt_p_nxt = cnt_p - 1'b1;
          q_clr     = 1'b1;
        end
      end
      prqs_pkg::CMD_ROTATE: begin
        if (lvl_ok) begin
          ok = 1'b1;
          // The old head moves behind the old tail; the new head's back link is never read.
          if (cnt_p > CW'(1)) begin
            head_we = 1'b1;
            head_wd = nx_head;
            tail_we = 1'b1;
            tail_wd = head_p;
            next_we = 1'b1;
            next_wa = tail_p;
            next_wd = head_p;
            prev_we = 1'b1;
            prev_wa = head_p;
            prev_wd = tail_p;
          end
        end
      end
      default: begin
        ok = 1'b1;
      end
    endcase
  end

  always_comb begin
    ready_nxt = ready_r;
    if (lvl_ok) begin
      ready_nxt[pi] = (cnt_p_nxt != '0);
    end
  end

  // Lowest-numbered non-empty level after the update, and its head.
  always_comb begin
    top_lvl = '0;
    for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
      if (ready_nxt[i]) begin
        top_lvl = LW'(i);
      end
    end
    top_v    = |ready_nxt;
    top_head = (head_we && top_lvl == pi) ? head_wd : head_r[top_lvl];
  end

  always_comb begin
    res_nxt.ok         = ok;
    res_nxt.top_valid  = top_v;
    res_nxt.top_task   = top_v ? prqs_pkg::TASK_W'(top_head) : '0;
    res_nxt.ready_mask = prqs_pkg::MASK_W'(ready_nxt);
    res_nxt.level_size = lvl_ok ? prqs_pkg::SIZE_W'(cnt_p_nxt) : '0;
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
      res_vld_r  <= 1'b0;
      queued_r   <= '0;
      ready_r    <= '0;
      cnt_r      <= '{default: '0};
    end else begin
      item_vld_r <= item_vld_nxt;
      res_vld_r  <= res_vld_nxt;
      if (adv) begin
        ready_r <= ready_nxt;
        if (lvl_ok) begin
          cnt_r[pi] <= cnt_p_nxt;
        end
        if (q_set) begin
          queued_r[ti] <= 1'b1;
        end
        if (q_clr) begin
          queued_r[ti] <= 1'b0;
        end
      end
    end
  end

  // Payload and link storage.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_data;
    end
    if (adv) begin
      res_r <= res_nxt;
      if (next_we) begin
        next_r[next_wa] <= next_wd;
      end
      if (prev_we) begin
        prev_r[prev_wa] <= prev_wd;
      end
      if (head_we) begin
        head_r[pi] <= head_wd;
      end
      if (tail_we) begin
        tail_r[pi] <= tail_wd;
      end
      if (q_set) begin
        qlvl_r[ti] <= pi;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_LEVELS; i++) begin
      cnt_nz[i] = (cnt_r[i] != '0);
    end
  end

  // The bitmap always agrees with the level counts.
  a_ready_matches_counts: assert property (@(posedge clk) disable iff (!rst_n)
    ready_r == cnt_nz)
    else $error("ready bitmap disagrees with level counts");

  // A result reports a top task exactly when some level is marked non-empty.
  a_top_valid_mask: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.top_valid == (out_data.ready_mask != '0)))
    else $error("top_valid inconsistent with ready_mask");

  // A query always succeeds.
  a_query_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && item_r.cmd == prqs_pkg::CMD_QUERY) |=> res_r.ok)
    else $error("query reported failure");

  // A full input register behind a stalled result must hold off new transfers.
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (item_vld_r && res_vld_r && !out_ready) |-> !in_ready)
    else $error("input taken while pipeline stalled");

endmodule
